// ===== hdl/c8s_pkg.sv =====
// Shared types and constants for the subset CHIP-8 core.
// Command and status bundles between controller and datapath.
// No dependencies.
package c8s_pkg;

  // Item operations on the request channel
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_RDPIX = 2'd2;
  localparam logic [1:0] OP_RDREG = 2'd3;

  // Instruction encodings
  localparam logic [15:0] INSTR_CLS = 16'h00E0;
  localparam logic [3:0]  NIB_SYS   = 4'h0;
  localparam logic [3:0]  NIB_JMP   = 4'h1;
  localparam logic [3:0]  NIB_LDV   = 4'h6;
  localparam logic [3:0]  NIB_LDI   = 4'hA;
  localparam logic [3:0]  NIB_DRW   = 4'hD;

  localparam logic [11:0] PC_RESET  = 12'h200;
  localparam logic [3:0]  REG_VF    = 4'hF;

  localparam int ROW_BITS  = 64;
  localparam int ROW_COUNT = 32;
  localparam int MEM_DEPTH = 4096;

  // Program memory read address select
  typedef enum logic [1:0] {
    MRD_PC,
    MRD_PC1,
    MRD_SPR
  } mrd_sel_t;

  // Register file read address select
  typedef enum logic [1:0] {
    RRD_ADDR,
    RRD_X,
    RRD_Y
  } rrd_sel_t;

  // Register file write select
  typedef enum logic [1:0] {
    RWR_NN,
    RWR_VF0,
    RWR_VF1
  } rwr_sel_t;

  // Decoded instruction class
  typedef enum logic [2:0] {
    CLS_CLR,
    CLS_JMP,
    CLS_LDV,
    CLS_LDI,
    CLS_DRW,
    CLS_UNK
  } cls_t;

  typedef struct packed {
    logic     latch_in;
    logic     clr_step;
    logic     mem_wr_in;
    logic     mem_rd_en;
    mrd_sel_t mrd_sel;
    logic     latch_hi;
    logic     latch_lo;
    logic     rf_rd_en;
    rrd_sel_t rrd_sel;
    logic     latch_vx;
    logic     latch_vy;
    logic     rf_wr_en;
    rwr_sel_t rwr_sel;
    logic     pc_wr;
    logic     pc_jump;
    logic     idx_wr;
    logic     fb_clear;
    logic     fb_rd_en;
    logic     fb_draw;
    logic     fb_wr;
    logic     row_clr;
    logic     row_inc;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    cls_t cls;
    logic n_zero;
    logic row_last;
    logic coll_any;
  } sts_t;

endpackage

// ===== hdl/c8s_datapath.sv =====
// Datapath of the subset CHIP-8 core: program memory, register file,
// frame store, PC/index, draw row logic and the result register.
// Depends on c8s_pkg.
module c8s_datapath
  import c8s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic [7:0]  out_read_data,
  output logic [11:0] out_program_counter,
  output logic [11:0] out_index_value,
  output logic [15:0] out_executed_word,
  output logic        out_status
);

  // Program memory and its clearing sweep
  logic [7:0]  pmem_r [MEM_DEPTH];
  logic [7:0]  pmem_q_r;
  logic [11:0] clr_cnt_r;
  logic [11:0] mem_ra;
  logic [11:0] mem_wa;
  logic [7:0]  mem_wd;
  logic        mem_we;

  // Register file, valid bit per entry
  logic [7:0]  rf_mem_r [16];
  logic [15:0] rf_vld_r;
  logic [7:0]  rf_q_r;
  logic        rf_vq_r;
  logic [3:0]  rf_ra;
  logic [3:0]  rf_wa;
  logic [7:0]  rf_wd;
  logic [7:0]  rf_val;

  // Frame store, one row per entry, valid bit per row
  logic [ROW_BITS-1:0]  fb_mem_r [ROW_COUNT];
  logic [ROW_COUNT-1:0] fb_vld_r;
  logic [ROW_BITS-1:0]  fb_q_r;
  logic                 fb_vq_r;
  logic [4:0]           fb_ra;
  logic [4:0]           draw_row;

  // Item and instruction state
  logic [1:0]  op_r;
  logic [11:0] addr_r;
  logic [7:0]  data_r;
  logic [7:0]  hi_r;
  logic [7:0]  lo_r;
  logic [15:0] word;
  logic [7:0]  vx_r;
  logic [7:0]  vy_r;
  logic [3:0]  row_r;
  logic        coll_r;
  logic [11:0] pc_r;
  logic [11:0] idx_r;
  cls_t        cls;

  // Draw row arithmetic
  logic [ROW_BITS-1:0]   spr_mask;
  logic [2*ROW_BITS-1:0] spr_wide;
  logic [ROW_BITS-1:0]   spr_rot;
  logic [ROW_BITS-1:0]   old_row;
  logic [ROW_BITS-1:0]   new_row;
  logic                  hit;

  // Result register
  logic [7:0]  res_rd_r;
  logic [11:0] res_pc_r;
  logic [11:0] res_idx_r;
  logic [15:0] res_word_r;
  logic        res_st_r;
  logic [7:0]  res_rd;

  assign word = {hi_r, lo_r};

  // Instruction decode
  always_comb begin
    unique case (word[15:12])
      NIB_SYS: cls = (word == INSTR_CLS) ? CLS_CLR : CLS_UNK;
      NIB_JMP: cls = CLS_JMP;
      NIB_LDV: cls = CLS_LDV;
      NIB_LDI: cls = CLS_LDI;
      NIB_DRW: cls = CLS_DRW;
      default: cls = CLS_UNK;
    endcase
  end

  // Item capture and instruction registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_opcode;
      addr_r <= in_address;
      data_r <= in_write_data;
    end
    if (cmd.latch_hi) hi_r <= pmem_q_r;
    if (cmd.latch_lo) lo_r <= pmem_q_r;
    if (cmd.latch_vx) vx_r <= rf_val;
    if (cmd.latch_vy) vy_r <= rf_val;
  end

  // Program memory ports
  always_comb begin
    case (cmd.mrd_sel)
      MRD_PC:  mem_ra = pc_r;
      MRD_PC1: mem_ra = pc_r + 12'd1;
      MRD_SPR: mem_ra = idx_r + {8'd0, row_r};
      default: mem_ra = pc_r;
    endcase
    mem_we = cmd.clr_step | cmd.mem_wr_in;
    mem_wa = cmd.clr_step ? clr_cnt_r : addr_r;
    mem_wd = cmd.clr_step ? 8'd0 : data_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) pmem_r[mem_wa] <= mem_wd;
    if (cmd.mem_rd_en) pmem_q_r <= pmem_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 12'd1;
    end
  end

  // Register file ports
  always_comb begin
    case (cmd.rrd_sel)
      RRD_ADDR: rf_ra = addr_r[3:0];
      RRD_X:    rf_ra = word[11:8];
      RRD_Y:    rf_ra = word[7:4];
      default:  rf_ra = addr_r[3:0];
    endcase
    case (cmd.rwr_sel)
      RWR_NN: begin
        rf_wa = word[11:8];
        rf_wd = word[7:0];
      end
      RWR_VF0: begin
        rf_wa = REG_VF;
        rf_wd = 8'd0;
      end
      RWR_VF1: begin
        rf_wa = REG_VF;
        rf_wd = 8'd1;
      end
      default: begin
        rf_wa = REG_VF;
        rf_wd = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rf_wr_en) rf_mem_r[rf_wa] <= rf_wd;
    if (cmd.rf_rd_en) begin
      rf_q_r  <= rf_mem_r[rf_ra];
      rf_vq_r <= rf_vld_r[rf_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (cmd.rf_wr_en) begin
      rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  assign rf_val = rf_vq_r ? rf_q_r : 8'd0;

  // Frame store ports
  assign draw_row = vy_r[4:0] + {1'b0, row_r};
  assign fb_ra    = cmd.fb_draw ? draw_row : addr_r[10:6];

  always_ff @(posedge clk) begin
    if (cmd.fb_wr) fb_mem_r[draw_row] <= new_row;
    if (cmd.fb_rd_en) begin
      fb_q_r  <= fb_mem_r[fb_ra];
      fb_vq_r <= fb_vld_r[fb_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_vld_r <= '0;
    end else if (cmd.fb_clear) begin
      fb_vld_r <= '0;
    end else if (cmd.fb_wr) begin
      fb_vld_r[draw_row] <= 1'b1;
    end
  end

  // Sprite byte placed at column VX, wrapped round the row
  always_comb begin
    spr_mask = '0;
    for (int c = 0; c < 8; c++) begin
      spr_mask[c] = pmem_q_r[7-c];
    end
    spr_wide = {spr_mask, spr_mask} << vx_r[5:0];
    spr_rot  = spr_wide[2*ROW_BITS-1:ROW_BITS];
    old_row  = fb_vq_r ? fb_q_r : '0;
    new_row  = old_row ^ spr_rot;
    hit      = |(old_row & spr_rot);
  end

  // Row counter and collision flag
  always_ff @(posedge clk) begin
    if (cmd.row_clr) begin
      row_r  <= '0;
      coll_r <= 1'b0;
    end else if (cmd.fb_wr) begin
      coll_r <= coll_r | hit;
      if (cmd.row_inc) row_r <= row_r + 4'd1;
    end
  end

  // Program counter and index register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= PC_RESET;
      idx_r <= '0;
    end else begin
      if (cmd.pc_wr) pc_r <= cmd.pc_jump ? word[11:0] : pc_r + 12'd2;
      if (cmd.idx_wr) idx_r <= word[11:0];
    end
  end

  // Result register
  always_comb begin
    case (op_r)
      OP_RDPIX: res_rd = {7'd0, ~addr_r[11] & old_row[addr_r[5:0]]};
      OP_RDREG: res_rd = (addr_r[11:4] == 8'd0) ? rf_val : 8'd0;
      default:  res_rd = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_rd_r   <= res_rd;
      res_pc_r   <= pc_r;
      res_idx_r  <= idx_r;
      res_word_r <= (op_r == OP_EXEC) ? word : 16'd0;
      res_st_r   <= (op_r == OP_EXEC) && (cls == CLS_UNK);
    end
  end

  assign out_read_data       = res_rd_r;
  assign out_program_counter = res_pc_r;
  assign out_index_value     = res_idx_r;
  assign out_executed_word   = res_word_r;
  assign out_status          = res_st_r;

  // Status back to the controller
  assign sts.clr_last = (clr_cnt_r == 12'(MEM_DEPTH - 1));
  assign sts.cls      = cls;
  assign sts.n_zero   = (word[3:0] == 4'd0);
  assign sts.row_last = ((row_r + 4'd1) == word[3:0]);
  assign sts.coll_any = coll_r | hit;

  // A row write always follows the read of that row
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fb_wr && $past(rst_n)) |-> $past(cmd.fb_rd_en && cmd.fb_draw))
    else $error("frame row written without a preceding draw read");

  // Index only moves on an index load
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.idx_wr)) |-> $stable(idx_r))
    else $error("index register changed without a load");

endmodule

// ===== hdl/c8s_ctrl.sv =====
// Controller state machine of the subset CHIP-8 core.
// Sequences clearing, item handling, fetch, decode and draw.
// Depends on c8s_pkg.
module c8s_ctrl
  import c8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_RDPIX = 4'd3;
  localparam logic [3:0] S_RDREG = 4'd4;
  localparam logic [3:0] S_F0    = 4'd5;
  localparam logic [3:0] S_F1    = 4'd6;
  localparam logic [3:0] S_F2    = 4'd7;
  localparam logic [3:0] S_DEC   = 4'd8;
  localparam logic [3:0] S_DX    = 4'd9;
  localparam logic [3:0] S_DY    = 4'd10;
  localparam logic [3:0] S_RR    = 4'd11;
  localparam logic [3:0] S_RW    = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mrd_sel = MRD_PC;
    cmd.rrd_sel = RRD_ADDR;
    cmd.rwr_sel = RWR_NN;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (in_opcode)
            OP_LOAD:  state_nxt = S_LOAD;
            OP_EXEC:  state_nxt = S_F0;
            OP_RDPIX: state_nxt = S_RDPIX;
            OP_RDREG: state_nxt = S_RDREG;
            default:  state_nxt = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        cmd.mem_wr_in = 1'b1;
        state_nxt = S_FIN;
      end
      S_RDPIX: begin
        cmd.fb_rd_en = 1'b1;
        state_nxt = S_FIN;
      end
      S_RDREG: begin
        cmd.rf_rd_en = 1'b1;
        state_nxt = S_FIN;
      end
      // Fetch the big-endian word at PC
      S_F0: begin
        cmd.mem_rd_en = 1'b1;
        state_nxt = S_F1;
      end
      S_F1: begin
        cmd.latch_hi  = 1'b1;
        cmd.mem_rd_en = 1'b1;
        cmd.mrd_sel   = MRD_PC1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.latch_lo = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.pc_wr = 1'b1;
        state_nxt = S_FIN;
        unique case (sts.cls)
          CLS_CLR: cmd.fb_clear = 1'b1;
          CLS_JMP: cmd.pc_jump = 1'b1;
          CLS_LDV: cmd.rf_wr_en = 1'b1;
          CLS_LDI: cmd.idx_wr = 1'b1;
          CLS_DRW: begin
            cmd.rf_rd_en = 1'b1;
            cmd.rrd_sel  = RRD_X;
            state_nxt = S_DX;
          end
          default: ;
        endcase
      end
      // Draw: fetch VX, VY, clear VF, then walk the sprite rows
      S_DX: begin
        cmd.latch_vx = 1'b1;
        cmd.rf_rd_en = 1'b1;
        cmd.rrd_sel  = RRD_Y;
        state_nxt = S_DY;
      end
      S_DY: begin
        cmd.latch_vy = 1'b1;
        cmd.rf_wr_en = 1'b1;
        cmd.rwr_sel  = RWR_VF0;
        cmd.row_clr  = 1'b1;
        state_nxt = sts.n_zero ? S_FIN : S_RR;
      end
      S_RR: begin
        cmd.mem_rd_en = 1'b1;
        cmd.mrd_sel   = MRD_SPR;
        cmd.fb_rd_en  = 1'b1;
        cmd.fb_draw   = 1'b1;
        state_nxt = S_RW;
      end
      S_RW: begin
        cmd.fb_wr = 1'b1;
        if (sts.row_last) begin
          cmd.rf_wr_en = sts.coll_any;
          cmd.rwr_sel  = RWR_VF1;
          state_nxt = S_FIN;
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt = S_RR;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.res_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A result appears only from the finishing state
  a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finishing state");

  // No result while program memory is still being cleared
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid_r)
    else $error("result present during memory clearing");

endmodule

// ===== hdl/chip8_subset_core.sv =====
// Top level of the subset CHIP-8 core.
// Joins the controller (c8s_ctrl) and the datapath (c8s_datapath); uses c8s_pkg.
//
// One request in, one result out. After reset the block clears its 4096-byte
// program memory, one byte per cycle, so in_stall stays high until the sweep
// ends and the first request can be taken. A memory load, pixel read or
// register read goes from its own state straight to the finishing state; an
// execute fetches the two bytes at PC and decodes them, and DXYN then reads VX
// and VY and does a read-modify-write of one frame row per sprite row.
// A finished result waits in the output register while the next request is
// taken. Clear screen resets the 32 row valid bits at once rather than
// sweeping the frame store.
module chip8_subset_core
  import c8s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [11:0] out_program_counter,
  output logic [11:0] out_index_value,
  output logic [15:0] out_executed_word,
  output logic        out_status
);

  cmd_t cmd;
  sts_t sts;

  c8s_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  c8s_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (in_opcode),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .out_read_data       (out_read_data),
    .out_program_counter (out_program_counter),
    .out_index_value     (out_index_value),
    .out_executed_word   (out_executed_word),
    .out_status          (out_status)
  );

endmodule
